### hw/rtl/rspe_pkg.sv
// Shared types, constants and GF(256) helpers for the Reed-Solomon parity encoder.
// It has no dependencies. Every other file of the encoder imports it.
`default_nettype none

package rspe_pkg;

    // Code geometry.
    localparam int DATA_SYMBOLS   = 11;
    localparam int PARITY_SYMBOLS = 4;
    localparam int BYTE_W         = 8;

    // Field polynomial x^8+x^4+x^3+x^2+1, low byte only.
    localparam logic [BYTE_W-1:0] GF_POLY_LOW = 8'h1D;
    localparam logic [BYTE_W-1:0] GF_ALPHA    = 8'h02;

    // Symbol counter and parity index widths.
    localparam int CNT_W = $clog2(DATA_SYMBOLS + 1);
    localparam int IDX_W = (PARITY_SYMBOLS > 1) ? $clog2(PARITY_SYMBOLS) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_SYMBOLS - 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(PARITY_SYMBOLS - 1);

    // Block queue between the front and the back.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam logic [QPTR_W-1:0] QPTR_LAST = QPTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QCNT_W-1:0] QCNT_FULL = QCNT_W'(QUEUE_DEPTH);

    // One block of parity bytes; entry 0 is the highest order byte.
    typedef logic [PARITY_SYMBOLS-1:0][BYTE_W-1:0] parity_block_t;

    // Generator coefficients; entry k is the coefficient of x^k.
    typedef logic [PARITY_SYMBOLS:0][BYTE_W-1:0] gen_poly_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Shift-and-add multiply in GF(256) with reduction by the field polynomial.
    function automatic logic [BYTE_W-1:0] gf_mul(
        input logic [BYTE_W-1:0] x,
        input logic [BYTE_W-1:0] y
    );
        logic [BYTE_W:0]   m;
        logic [BYTE_W-1:0] acc;
        acc = '0;
        m   = {1'b0, x};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if (y[k])
            begin
                acc = acc ^ m[BYTE_W-1:0];
            end
            m = {m[BYTE_W-1:0], 1'b0};
            if (m[BYTE_W])
            begin
                m = {1'b0, m[BYTE_W-1:0] ^ GF_POLY_LOW};
            end
        end
        return acc;
    endfunction

    // Product of (x + a^i) for i = 1 .. PARITY_SYMBOLS, evaluated at elaboration.
    function automatic gen_poly_t build_gen();
        gen_poly_t         c;
        logic [BYTE_W-1:0] root;
        c    = '0;
        c[0] = 8'd1;
        root = 8'd1;
        for (int i = 1; i <= PARITY_SYMBOLS; i++)
        begin
            root = gf_mul(root, GF_ALPHA);
            c[i] = c[i-1];
            for (int j = i - 1; j > 0; j--)
            begin
                c[j] = c[j-1] ^ gf_mul(c[j], root);
            end
            c[0] = gf_mul(c[0], root);
        end
        return c;
    endfunction

    localparam gen_poly_t GEN_COEF = build_gen();

endpackage

`default_nettype wire

### hw/rtl/rspe_in_if.sv
// Request channel that carries one data byte per request.
// Depends on rspe_pkg for the byte width.
`default_nettype none

interface rspe_in_if import rspe_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink   (input valid, input data_byte, output ready);
endinterface

`default_nettype wire

### hw/rtl/rspe_out_if.sv
// Request channel that carries one parity byte and its end-of-block flag.
// Depends on rspe_pkg for the byte width.
`default_nettype none

interface rspe_out_if import rspe_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] parity_byte;
    logic              parity_last;

    modport source (output valid, output parity_byte, output parity_last, input ready);
    modport sink   (input valid, input parity_byte, input parity_last, output ready);
endinterface

`default_nettype wire

### hw/rtl/rspe_front.sv
// Front end: takes data bytes, runs the parity LFSR and counts bytes per block.
// Depends on rspe_pkg and rspe_in_if; hands finished blocks to the queue.
`default_nettype none

module rspe_front import rspe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    rspe_in_if.sink      data_ch,
    input  wire qstat_t  qstat,
    output logic         push,
    output parity_block_t block
);

    parity_block_t    par_reg;
    parity_block_t    par_next;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic [BYTE_W-1:0] fb;
    logic             accept;
    logic             at_last;

    // Only the byte that closes a block needs room in the queue.
    assign at_last       = (cnt_reg == CNT_LAST);
    assign data_ch.ready = !qstat.full || !at_last;
    assign accept        = data_ch.valid && data_ch.ready;
    assign push          = accept && at_last;

    // One LFSR step through the constant generator multipliers.
    always_comb
    begin
        fb = data_ch.data_byte ^ par_reg[0];
        for (int j = 0; j < PARITY_SYMBOLS - 1; j++)
        begin
            block[j] = par_reg[j+1] ^ gf_mul(GEN_COEF[PARITY_SYMBOLS-1-j], fb);
        end
        block[PARITY_SYMBOLS-1] = gf_mul(GEN_COEF[0], fb);
    end

    // The register and the counter clear when a block completes.
    always_comb
    begin
        par_next = par_reg;
        cnt_next = cnt_reg;
        if (accept)
        begin
            if (at_last)
            begin
                par_next = '0;
                cnt_next = '0;
            end
            else
            begin
                par_next = block;
                cnt_next = cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            par_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            par_reg <= par_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rspe_queue.sv
// Short queue of finished parity blocks between the front and the back.
// Depends on rspe_pkg for the block type and the queue depth.
`default_nettype none

module rspe_queue import rspe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    push,
    input  wire parity_block_t push_block,
    input  wire logic    pop,
    output parity_block_t head,
    output qstat_t       qstat
);

    parity_block_t     entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;

    assign qstat.full  = (cnt_reg == QCNT_FULL);
    assign qstat.empty = (cnt_reg == '0);
    assign head        = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_LAST) ? '0 : wr_ptr_reg + QPTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_LAST) ? '0 : rd_ptr_reg + QPTR_W'(1);
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // Block storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_block;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/rspe_back.sv
// Back end: pulls parity blocks from the queue and drains them byte by byte.
// Depends on rspe_pkg and rspe_out_if.
`default_nettype none

module rspe_back import rspe_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire qstat_t  qstat,
    input  wire parity_block_t head,
    output logic         pop,
    rspe_out_if.source   parity_ch
);

    parity_block_t    drain_reg;
    parity_block_t    drain_next;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             busy_reg;
    logic             busy_next;
    logic             taken;
    logic             is_last;

    assign is_last               = (idx_reg == IDX_LAST);
    assign parity_ch.valid       = busy_reg;
    assign parity_ch.parity_byte = drain_reg[0];
    assign parity_ch.parity_last = is_last;
    assign taken                 = busy_reg && parity_ch.ready;

    // Load the next block when idle or as the last byte of this one leaves.
    assign pop = !qstat.empty && (!busy_reg || (taken && is_last));

    always_comb
    begin
        drain_next = drain_reg;
        idx_next   = idx_reg;
        busy_next  = busy_reg;
        if (pop)
        begin
            drain_next = head;
            idx_next   = '0;
            busy_next  = 1'b1;
        end
        else if (taken)
        begin
            if (is_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                for (int j = 0; j < PARITY_SYMBOLS - 1; j++)
                begin
                    drain_next[j] = drain_reg[j+1];
                end
                idx_next = idx_reg + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg  <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            idx_reg  <= idx_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        drain_reg <= drain_next;
    end

endmodule

`default_nettype wire

### hw/rtl/reed_solomon_parity_encoder_unit.sv
// Reed-Solomon RS(15,11)-style parity encoder over GF(256), top level.
// Depends on rspe_pkg, rspe_in_if, rspe_out_if, rspe_front, rspe_queue and rspe_back.
//
// Usage: data_ch takes one message byte per request, DATA_SYMBOLS bytes per block.
// parity_ch returns PARITY_SYMBOLS parity bytes per block, highest order first,
// with parity_last set on the final one.
// Throughput: one data byte per cycle but for a closing byte held by a full queue.
// The LFSR steps once per byte. A finished block passes the queue and the drain
// register; its parity bytes follow one per cycle while the receiver is ready.
// Finished blocks wait in a two-entry queue, so the next block starts at once.
// A stalled receiver holds the current parity byte. Data bytes keep flowing
// until a block completes with the queue full; only that closing byte waits.
// Reset clears the parity register, the byte counter, the queue and the
// drain stage; no parity request is pending after reset.
`default_nettype none

module reed_solomon_parity_encoder_unit import rspe_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    rspe_in_if.sink    data_ch,
    rspe_out_if.source parity_ch
);

    logic          push;
    logic          pop;
    parity_block_t push_block;
    parity_block_t head;
    qstat_t        qstat;

    // Byte intake and LFSR.
    rspe_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .data_ch (data_ch),
        .qstat   (qstat),
        .push    (push),
        .block   (push_block)
    );

    // Queue of finished blocks.
    rspe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_block (push_block),
        .pop        (pop),
        .head       (head),
        .qstat      (qstat)
    );

    // Parity drain.
    rspe_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .qstat     (qstat),
        .head      (head),
        .pop       (pop),
        .parity_ch (parity_ch)
    );

`ifndef SYNTHESIS
    // A finished block is never written into a full queue.
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("parity block pushed into a full queue");

    // The front only stalls when the queue has no room.
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !data_ch.ready |-> qstat.full)
        else $error("data request stalled with room in the queue");

    // The back never takes a block from an empty queue.
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("parity block popped from an empty queue");

    // After the last byte of a block with nothing queued, the output goes idle.
    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (parity_ch.valid && parity_ch.ready && parity_ch.parity_last && qstat.empty)
        |=> !parity_ch.valid)
        else $error("parity output stayed valid after the block drained");
`endif

endmodule

`default_nettype wire
